>>> rtl/cra_pkg.sv
// ---------------------------------------------------------------------------
// cra_pkg
// Shared types and constants of the compacting region allocator.
// ---------------------------------------------------------------------------
package cra_pkg;

  localparam int REGION_WORDS = 256;
  localparam int OBJECT_SLOTS = 16;
  localparam int SLOT_W       = 4;
  localparam int WORD_W       = 8;
  localparam int LEN_W        = 9;
  localparam int TOP_W        = 9;
  localparam int STATUS_W     = 3;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_SLOT  = 3'd1,
    ST_NO_ROOM  = 3'd2,
    ST_ZERO_LEN = 3'd3,
    ST_UNUSED   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CHECK,
    FSM_WAIT,
    FSM_EMIT
  } fsm_t;

  // command token handed from cell to cell
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [SLOT_W-1:0] id;
    logic [WORD_W-1:0] s;
    logic [WORD_W-1:0] e;
    logic [LEN_W-1:0]  flen;
    logic [SLOT_W-1:0] pos;
    logic              found;
    logic [SLOT_W-1:0] free_idx;
  } tok_t;

  typedef struct packed {
    logic              used;
    logic [WORD_W-1:0] start_w;
    logic [WORD_W-1:0] end_w;
  } slot_rd_t;

endpackage

>>> rtl/cra_cell.sv
// ---------------------------------------------------------------------------
// cra_cell
// One object slot: applies the passing command token to its own entry,
// records the first free slot seen so far, and forwards the token.
// ---------------------------------------------------------------------------
module cra_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  cra_pkg::tok_t   tok_i,
  output cra_pkg::tok_t   tok_o,
  output cra_pkg::slot_rd_t slot_o
);
  import cra_pkg::*;

  logic              used_r, used_nxt;
  logic [WORD_W-1:0] start_r, start_nxt;
  logic [WORD_W-1:0] end_r, end_nxt;
  tok_t              tok_r, tok_nxt;
  logic              match;

  always_comb begin
    match     = tok_i.valid && (tok_i.pos == tok_i.id);
    used_nxt  = used_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    tok_nxt   = tok_i;
    if (tok_i.valid) begin
      if (tok_i.op == OP_ALLOC) begin
        if (match) begin
          used_nxt  = 1'b1;
          start_nxt = tok_i.s;
          end_nxt   = tok_i.e;
        end
      end else begin
        if (match) begin
          used_nxt = 1'b0;
        end else if (used_r && (start_r > tok_i.s)) begin
          // slide down by the freed length
          start_nxt = start_r - tok_i.flen[WORD_W-1:0];
          end_nxt   = end_r - tok_i.flen[WORD_W-1:0];
        end
      end
      if (!tok_i.found && !used_nxt) begin
        tok_nxt.found    = 1'b1;
        tok_nxt.free_idx = tok_i.pos;
      end
      tok_nxt.pos = tok_i.pos + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      tok_r  <= '0;
    end else begin
      used_r <= used_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    end_r   <= end_nxt;
  end

  assign tok_o          = tok_r;
  assign slot_o.used    = used_r;
  assign slot_o.start_w = start_r;
  assign slot_o.end_w   = end_r;

endmodule

>>> rtl/cra_chain.sv
// ---------------------------------------------------------------------------
// cra_chain
// Row of slot cells. A launched token walks the row one cell per cycle;
// a slot can be read by index for the free lookup.
// ---------------------------------------------------------------------------
module cra_chain (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cra_pkg::tok_t             launch_i,
  input  logic [cra_pkg::SLOT_W-1:0] rd_id_i,
  output cra_pkg::slot_rd_t         rd_o,
  output cra_pkg::tok_t             done_o,
  output logic                      busy_o
);
  import cra_pkg::*;

  tok_t     tok   [0:OBJECT_SLOTS];
  slot_rd_t slots [0:OBJECT_SLOTS-1];
  logic [OBJECT_SLOTS-1:0] act;

  assign tok[0] = launch_i;

  for (genvar k = 0; k < OBJECT_SLOTS; k++) begin : g_cell
    cra_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1]),
      .slot_o (slots[k])
    );
    assign act[k] = tok[k+1].valid;
  end

  assign rd_o   = slots[rd_id_i];
  assign done_o = tok[OBJECT_SLOTS];
  assign busy_o = |act;

endmodule

>>> rtl/compacting_region_allocator_core.sv
// ---------------------------------------------------------------------------
// compacting_region_allocator_core
// Slot table allocator that keeps one region compact on every free.
// From input transfer to result transfer: the check state, which also feeds
// the first slot cell, the token's walk through each further cell, the wait
// state that takes the finished token, the emit state that loads the output
// register, which then offers the result. Error results skip the chain. Only
// one command is in flight; the next input is taken once the result is loaded.
// Reset (synchronous, rst_n low) frees every slot, clears region top and
// points the next slot at slot zero.
// ---------------------------------------------------------------------------
module compacting_region_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // length[8:0], object_id[12:9]
  input  logic [0:0]  in_tuser,   // op[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // slot_index[3:0], start_index[11:4], end_index[19:12]
  output logic [2:0]  out_tuser   // status[2:0]
);
  import cra_pkg::*;

  fsm_t              state_r, state_nxt;
  op_t               cmd_op_r;
  logic [LEN_W-1:0]  cmd_len_r;
  logic [SLOT_W-1:0] cmd_id_r;

  logic [TOP_W-1:0]  top_r, top_nxt;
  logic [SLOT_W-1:0] nslot_r, nslot_nxt;
  logic              nvalid_r, nvalid_nxt;
  logic [TOP_W-1:0]  new_top_r, new_top_nxt;

  status_t           res_status_r, res_status_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [WORD_W-1:0] res_s_r, res_s_nxt;
  logic [WORD_W-1:0] res_e_r, res_e_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [WORD_W-1:0] out_s_r, out_s_nxt;
  logic [WORD_W-1:0] out_e_r, out_e_nxt;

  tok_t              launch;
  tok_t              done;
  slot_rd_t          rd;
  logic              busy;
  logic [TOP_W:0]    alloc_sum;
  logic [TOP_W-1:0]  alloc_e;
  logic [LEN_W-1:0]  free_len;

  cra_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .launch_i (launch),
    .rd_id_i  (cmd_id_r),
    .rd_o     (rd),
    .done_o   (done),
    .busy_o   (busy)
  );

  assign in_tready = (state_r == FSM_IDLE);

  always_comb begin
    state_nxt      = state_r;
    top_nxt        = top_r;
    nslot_nxt      = nslot_r;
    nvalid_nxt     = nvalid_r;
    new_top_nxt    = new_top_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_s_nxt      = res_s_r;
    res_e_nxt      = res_e_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_s_nxt      = out_s_r;
    out_e_nxt      = out_e_r;
    launch         = '0;
    alloc_sum      = {1'b0, top_r} + {1'b0, cmd_len_r};
    alloc_e        = top_r + cmd_len_r - TOP_W'(1);
    free_len       = {1'b0, rd.end_w} - {1'b0, rd.start_w} + LEN_W'(1);

    case (state_r)
      FSM_IDLE: begin
        if (in_tvalid) begin
          state_nxt = FSM_CHECK;
        end
      end
      FSM_CHECK: begin
        res_status_nxt = ST_OK;
        res_slot_nxt   = '0;
        res_s_nxt      = '0;
        res_e_nxt      = '0;
        state_nxt      = FSM_EMIT;
        if (cmd_op_r == OP_ALLOC) begin
          if (cmd_len_r == '0) begin
            res_status_nxt = ST_ZERO_LEN;
          end else if (!nvalid_r) begin
            res_status_nxt = ST_NO_SLOT;
          end else if (alloc_sum > (TOP_W+1)'(REGION_WORDS)) begin
            res_status_nxt = ST_NO_ROOM;
          end else begin
            res_slot_nxt  = nslot_r;
            res_s_nxt     = top_r[WORD_W-1:0];
            res_e_nxt     = alloc_e[WORD_W-1:0];
            new_top_nxt   = alloc_sum[TOP_W-1:0];
            launch.valid  = 1'b1;
            launch.op     = OP_ALLOC;
            launch.id     = nslot_r;
            launch.s      = top_r[WORD_W-1:0];
            launch.e      = alloc_e[WORD_W-1:0];
            launch.flen   = cmd_len_r;
            state_nxt     = FSM_WAIT;
          end
        end else begin
          res_slot_nxt = cmd_id_r;
          if (!rd.used) begin
            res_status_nxt = ST_UNUSED;
          end else begin
            res_s_nxt    = rd.start_w;
            res_e_nxt    = rd.end_w;
            new_top_nxt  = (top_r >= free_len) ? (top_r - free_len) : '0;
            launch.valid = 1'b1;
            launch.op    = OP_FREE;
            launch.id    = cmd_id_r;
            launch.s     = rd.start_w;
            launch.e     = rd.end_w;
            launch.flen  = free_len;
            state_nxt    = FSM_WAIT;
          end
        end
      end
      FSM_WAIT: begin
        if (done.valid) begin
          top_nxt    = new_top_r;
          nslot_nxt  = done.found ? done.free_idx : '0;
          nvalid_nxt = done.found;
          state_nxt  = FSM_EMIT;
        end
      end
      FSM_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_s_nxt      = res_s_r;
          out_e_nxt      = res_e_r;
          state_nxt      = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      top_r       <= '0;
      nslot_r     <= '0;
      nvalid_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      nslot_r     <= nslot_nxt;
      nvalid_r    <= nvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_op_r  <= op_t'(in_tuser[0]);
      cmd_len_r <= in_tdata[8:0];
      cmd_id_r  <= in_tdata[12:9];
    end
    new_top_r    <= new_top_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_s_r      <= res_s_nxt;
    res_e_r      <= res_e_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_s_r      <= out_s_nxt;
    out_e_r      <= out_e_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_e_r, out_s_r, out_slot_r};
  assign out_tuser  = out_status_r;

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= TOP_W'(REGION_WORDS))
    else $error("region top beyond region size");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    done.valid |-> state_r == FSM_WAIT)
    else $error("chain token finished outside wait");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FSM_IDLE |-> !busy)
    else $error("chain busy while idle");

  a_free_gives_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_WAIT && done.valid && cmd_op_r == OP_FREE) |=> nvalid_r)
    else $error("no free slot after a free");

endmodule

>>> tb/sv/tb_compacting_region_allocator_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_compacting_region_allocator_core
// Streams allocate and free commands into the allocator and predicts each
// status, slot and word range from a local copy of the slot table. Results
// are matched in order. Both sides idle in random bursts, and the result
// side holds off once for a long stretch so the command side backs up.
// ---------------------------------------------------------------------------
module tb_compacting_region_allocator_core;
  import cra_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT = 120;

  typedef struct packed {
    op_t               op;
    logic [LEN_W-1:0]  length;
    logic [SLOT_W-1:0] object_id;
  } alloc_cmd_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] first_w;
    logic [WORD_W-1:0] last_w;
  } alloc_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // length[8:0], object_id[12:9]
  logic [0:0]  in_tuser = '0;   // op[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // slot_index[3:0], start_index[11:4], end_index[19:12]
  logic [2:0]  out_tuser;       // status[2:0]

  compacting_region_allocator_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // shadow slot table
  logic              used_q [OBJECT_SLOTS];
  logic [WORD_W-1:0] start_q [OBJECT_SLOTS];
  logic [WORD_W-1:0] end_q [OBJECT_SLOTS];
  int                top_q;
  logic [SLOT_W-1:0] next_q;
  logic              next_ok_q;

  alloc_cmd_t cmd_q[$];
  alloc_rsp_t result_q[$];
  int n_items = 0;
  int in_count = 0;
  int errors = 0;
  bit in_taken = 1'b0;
  logic calm;

  assign calm = (in_count >= 200 && in_count < 260) || (in_count >= n_items - 60);

  function automatic void pick_lowest_free();
    next_ok_q = 1'b0;
    next_q = '0;
    for (int i = OBJECT_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        next_q = SLOT_W'(i);
        next_ok_q = 1'b1;
      end
    end
  endfunction

  function automatic alloc_rsp_t alloc_apply(alloc_cmd_t c);
    alloc_rsp_t r;
    int s;
    int e;
    int flen;
    r = '{status: ST_OK, slot: '0, first_w: '0, last_w: '0};
    if (c.op == OP_ALLOC) begin
      if (c.length == 0) begin
        r.status = ST_ZERO_LEN;
      end else if (!next_ok_q) begin
        r.status = ST_NO_SLOT;
      end else if (top_q + int'(c.length) > REGION_WORDS) begin
        r.status = ST_NO_ROOM;
      end else begin
        s = top_q;
        e = top_q + int'(c.length) - 1;
        used_q[next_q] = 1'b1;
        start_q[next_q] = WORD_W'(s);
        end_q[next_q] = WORD_W'(e);
        top_q = top_q + int'(c.length);
        r.slot = next_q;
        r.first_w = WORD_W'(s);
        r.last_w = WORD_W'(e);
        pick_lowest_free();
      end
    end else begin
      r.slot = c.object_id;
      if (!used_q[c.object_id]) begin
        r.status = ST_UNUSED;
      end else begin
        s = int'(start_q[c.object_id]);
        e = int'(end_q[c.object_id]);
        flen = e - s + 1;
        used_q[c.object_id] = 1'b0;
        // slide everything above the freed object down
        for (int j = 0; j < OBJECT_SLOTS; j++) begin
          if (used_q[j] && int'(start_q[j]) > s) begin
            start_q[j] = WORD_W'(int'(start_q[j]) - flen);
            end_q[j] = WORD_W'(int'(end_q[j]) - flen);
          end
        end
        top_q = (top_q >= flen) ? top_q - flen : 0;
        r.first_w = WORD_W'(s);
        r.last_w = WORD_W'(e);
        pick_lowest_free();
      end
    end
    return r;
  endfunction

  task automatic push_cmd(op_t op, int length, int object_id);
    alloc_cmd_t c;
    c.op = op;
    c.length = LEN_W'(length);
    c.object_id = SLOT_W'(object_id);
    cmd_q.push_back(c);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    int r;
    bit free_heavy;
    for (int i = 0; i < OBJECT_SLOTS; i++) begin
      used_q[i] = 1'b0;
      start_q[i] = '0;
      end_q[i] = '0;
    end
    top_q = 0;
    next_q = '0;
    next_ok_q = 1'b1;

    // directed corners
    push_cmd(OP_ALLOC, 0, 9);
    push_cmd(OP_FREE, 0, 5);
    push_cmd(OP_ALLOC, 255, 0);
    push_cmd(OP_ALLOC, 2, 15);
    push_cmd(OP_ALLOC, 1, 0);
    push_cmd(OP_FREE, 256, 0);
    push_cmd(OP_FREE, 0, 1);
    push_cmd(OP_ALLOC, 256, 0);
    push_cmd(OP_FREE, 0, 0);
    for (int i = 0; i < OBJECT_SLOTS; i++) push_cmd(OP_ALLOC, i + 1, 0);
    push_cmd(OP_ALLOC, 3, 0);

    // random: alternate fill-heavy and drain-heavy stretches
    free_heavy = 1'b1;
    for (int i = 0; i < 500; i++) begin
      if (i % 20 == 0) free_heavy = ($urandom_range(0, 1) == 1);
      if ($urandom_range(0, 99) < (free_heavy ? 25 : 75)) begin
        r = $urandom_range(0, 99);
        if (r < 5) push_cmd(OP_ALLOC, 0, $urandom_range(0, 15));
        else if (r < 75) push_cmd(OP_ALLOC, $urandom_range(1, 24), $urandom_range(0, 15));
        else if (r < 92) push_cmd(OP_ALLOC, $urandom_range(25, 128), $urandom_range(0, 15));
        else push_cmd(OP_ALLOC, $urandom_range(129, 256), $urandom_range(0, 15));
      end else begin
        push_cmd(OP_FREE, $urandom_range(0, 256), $urandom_range(0, 15));
      end
    end
    n_items = cmd_q.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (in_count < n_items) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb_compacting_region_allocator_core: done, clean");
    end else begin
      $display("tb_compacting_region_allocator_core: done, errors");
    end
    $finish;
  end

  // command driver
  always @(negedge clk) begin
    int gap_left;
    logic nv;
    alloc_cmd_t c;
    if (rst_n && !(in_tvalid && !in_taken)) begin
      in_taken = 1'b0;
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 7);
      end else if (cmd_q.size() > 0) begin
        c = cmd_q.pop_front();
        in_tdata <= {3'b000, c.object_id, c.length};
        in_tuser <= c.op;
        nv = 1'b1;
      end
      in_tvalid <= nv;
    end
  end

  // result side ready, with one long hold-off
  always @(negedge clk) begin
    int hold_left;
    int stall_left;
    bit held_off;
    logic rdy;
    if (rst_n) begin
      rdy = 1'b1;
      if (!held_off && in_count >= HOLD_AT) begin
        held_off = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        rdy = 1'b0;
      end
      out_tready <= rdy;
    end
  end

  // transfer monitor and checker
  always @(posedge clk) begin
    alloc_cmd_t c;
    alloc_rsp_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        c.op = op_t'(in_tuser[0]);
        c.length = in_tdata[8:0];
        c.object_id = in_tdata[12:9];
        result_q.push_back(alloc_apply(c));
        in_count++;
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, actual status %0d data %h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = result_q.pop_front();
          check_field("status", int'(want.status), int'(out_tuser));
          check_field("slot_index", int'(want.slot), int'(out_tdata[3:0]));
          check_field("start_index", int'(want.first_w), int'(out_tdata[11:4]));
          check_field("end_index", int'(want.last_w), int'(out_tdata[19:12]));
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    int idle_cycles;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("tb_compacting_region_allocator_core: done, errors");
        $finish;
      end
    end
  end

endmodule
